@@ rtl/bale_pkg.sv @@
// Shared types and constants for the bounded array list engine.
package bale_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 11;
   localparam int FIELD_W = 11;

   typedef enum logic [2:0] {
      OP_INSERT     = 3'd0,
      OP_DELETE_AT  = 3'd1,
      OP_UPDATE_AT  = 3'd2,
      OP_SEARCH     = 3'd3,
      OP_COUNT      = 3'd4,
      OP_REPLACE    = 3'd5,
      OP_DELETE_ALL = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT_UP,
      ST_PUT,
      ST_SHIFT_DOWN,
      ST_SCAN,
      ST_DRAIN
   } state_type;

endpackage

@@ rtl/bale_ram.sv @@
// Entry store: one write port, one read port with registered read data.
module bale_ram
   import bale_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [VALUE_W-1:0]         rd_data,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [VALUE_W-1:0]         wr_data
);

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bounded_array_list_engine.sv @@
// Top level: request sequencer around the entry store.
//
//  channel   ports                                         handshake
//  request   req_op, req_value, req_new_value, req_position start & !busy
//  result    rsp_ok, rsp_match_count, rsp_length            rsp_strobe, one cycle
//
// Update and rejected requests answer from idle. Insert and delete-at shift
// the tail of the list one entry at a time; search, count, replace-first and
// delete-all walk every valid entry, paced by the single read port of the
// store. Reset clears the length and control state; the store needs no pass.
// The result strobe cannot be stalled; busy drops in the cycle it is shown.
module bounded_array_list_engine
   import bale_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_op,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic signed [VALUE_W-1:0] req_new_value,
   input  logic [POS_W-1:0]          req_position,
   output logic                      rsp_strobe,
   output logic                      rsp_ok,
   output logic [FIELD_W-1:0]        rsp_match_count,
   output logic [FIELD_W-1:0]        rsp_length
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [VALUE_W-1:0] new_value_ff, new_value_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      cursor_ff, cursor_in;
   logic [CW-1:0]      wptr_ff, wptr_in;
   logic [CW-1:0]      tally_ff, tally_in;
   logic               found_ff, found_in;
   logic [AW-1:0]      first_ff, first_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      pend_addr_ff, pend_addr_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [CW-1:0]      rsp_match_ff, rsp_match_in;
   logic [CW-1:0]      rsp_len_ff;

   logic               rd_en, wr_en;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [VALUE_W-1:0] rd_data, wr_data;

   logic [XW-1:0] x_pos, x_count, x_cursor, x_match, x_len, x_req_pos;
   logic [CW-1:0] cursor_dec, cursor_inc;
   logic          hit;

   bale_ram #(.DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff        <= op_in;
      value_ff     <= value_in;
      new_value_ff <= new_value_in;
      pos_ff       <= pos_in;
      cursor_ff    <= cursor_in;
      wptr_ff      <= wptr_in;
      tally_ff     <= tally_in;
      found_ff     <= found_in;
      first_ff     <= first_in;
      pend_addr_ff <= pend_addr_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_match_ff <= rsp_match_in;
      rsp_len_ff   <= count_in;
   end

   assign x_pos      = XW'(pos_ff);
   assign x_req_pos  = XW'(req_position);
   assign x_count    = XW'(count_ff);
   assign x_cursor   = XW'(cursor_ff);
   assign cursor_dec = cursor_ff - CW'(1);
   assign cursor_inc = cursor_ff + CW'(1);
   assign hit        = (rd_data == value_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      new_value_in  = new_value_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      wptr_in       = wptr_ff;
      tally_in      = tally_ff;
      found_in      = found_ff;
      first_in      = first_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      rsp_strobe_in = 1'b0;
      rsp_ok_in     = 1'b0;
      rsp_match_in  = '0;
      rd_en         = 1'b0;
      rd_addr       = cursor_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = pend_addr_ff;
      wr_data       = rd_data;

      // data read last cycle arrives now
      if (pend_ff) begin
         if (op_ff == OP_INSERT || op_ff == OP_DELETE_AT) begin
            wr_en = 1'b1;
         end else begin
            if (hit) begin
               tally_in = tally_ff + CW'(1);
               if (!found_ff) begin
                  found_in = 1'b1;
                  first_in = pend_addr_ff;
               end
            end
            if (op_ff == OP_DELETE_ALL && !hit) begin
               wr_en   = 1'b1;
               wr_addr = wptr_ff[AW-1:0];
               wptr_in = wptr_ff + CW'(1);
            end
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in        = op_type'(req_op);
               value_in     = req_value;
               new_value_in = req_new_value;
               pos_in       = req_position;
               found_in     = 1'b0;
               tally_in     = '0;
               wptr_in      = '0;
               unique case (op_type'(req_op))
                  OP_INSERT: begin
                     if (count_ff < CW'(CAPACITY) && x_req_pos <= x_count) begin
                        cursor_in = count_ff;
                        state_in  = ST_SHIFT_UP;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  OP_DELETE_AT: begin
                     if (x_req_pos < x_count) begin
                        cursor_in = CW'(x_req_pos) + CW'(1);
                        state_in  = ST_SHIFT_DOWN;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  OP_UPDATE_AT: begin
                     rsp_strobe_in = 1'b1;
                     if (x_req_pos < x_count) begin
                        wr_en     = 1'b1;
                        wr_addr   = x_req_pos[AW-1:0];
                        wr_data   = req_value;
                        rsp_ok_in = 1'b1;
                     end
                  end
                  OP_SEARCH, OP_COUNT, OP_REPLACE, OP_DELETE_ALL: begin
                     if (count_ff != '0) begin
                        cursor_in = '0;
                        state_in  = ST_SCAN;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SHIFT_UP: begin
            if (x_cursor > x_pos) begin
               rd_en        = 1'b1;
               rd_addr      = cursor_dec[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = cursor_ff[AW-1:0];
               cursor_in    = cursor_dec;
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (!pend_ff) begin
               wr_en         = 1'b1;
               wr_addr       = x_pos[AW-1:0];
               wr_data       = value_ff;
               count_in      = count_ff + CW'(1);
               rsp_strobe_in = 1'b1;
               rsp_ok_in     = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SHIFT_DOWN: begin
            if (cursor_ff < count_ff) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = cursor_dec[AW-1:0];
               cursor_in    = cursor_inc;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_SCAN: begin
            if (cursor_ff < count_ff) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = cursor_ff[AW-1:0];
               cursor_in    = cursor_inc;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pend_ff) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
               unique case (op_ff)
                  OP_DELETE_AT: begin
                     count_in  = count_ff - CW'(1);
                     rsp_ok_in = 1'b1;
                  end
                  OP_COUNT: begin
                     rsp_ok_in    = 1'b1;
                     rsp_match_in = tally_ff;
                  end
                  OP_REPLACE: begin
                     rsp_ok_in = found_ff;
                     if (found_ff) begin
                        wr_en   = 1'b1;
                        wr_addr = first_ff;
                        wr_data = new_value_ff;
                     end
                  end
                  OP_DELETE_ALL: begin
                     count_in  = wptr_ff;
                     rsp_ok_in = 1'b1;
                  end
                  default: begin
                     rsp_ok_in = found_ff;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign x_match = XW'(rsp_match_ff);
   assign x_len   = XW'(rsp_len_ff);

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_match_count = x_match[FIELD_W-1:0];
   assign rsp_length      = x_len[FIELD_W-1:0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("length above capacity");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> state_ff == ST_IDLE)
      else $error("result shown while busy");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> rd_addr != wr_addr)
      else $error("read and write to the same entry");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe_ff))
      else $error("accepted item neither worked nor answered");

   a_pend_active: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff != ST_IDLE)
      else $error("read data pending while idle");

endmodule
